[rtl/eit_pkg.sv]
// ----------------------------------------------------------------------------
// eit_pkg
// Shared types and constants for the event interest table.
// ----------------------------------------------------------------------------
`default_nettype none

package eit_pkg;

  localparam int EIT_ENTRIES     = 16;
  localparam int EIT_ONESHOT_BIT = 30;

  localparam int MODE_W       = 3;
  localparam int SRC_W        = 16;
  localparam int MASK_W       = 32;
  localparam int DATA_W       = 64;
  localparam int WANT_W       = 5;
  localparam int STATUS_W     = 2;
  localparam int MOST_RESULTS = 16;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 112;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD     = 3'd0,
    OP_MODIFY  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_NOTIFY  = 3'd3,
    OP_HARVEST = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    step;
    logic    wr_add;
    logic    wr_mod;
    logic    del;
    logic    wr_notify;
    logic    take;
    logic    emit;
    status_t emit_status;
  } eit_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              at_end;
    logic              vld;
    logic              match;
    logic              overlap;
    logic              ready_nz;
    logic              want_zero;
    logic              want_hit;
    logic              pend_vld;
    logic              out_free;
  } eit_sts_t;

endpackage

`default_nettype wire

[rtl/event_interest_table.sv]
// ----------------------------------------------------------------------------
// event_interest_table
// Table of event interest slots with add, modify, delete, notify and
// harvest of ready entries.
//
//   port group   dir   tuser          tdata                               tlast
//   in_*         in    mode[2:0]      source_id, event_mask, user_data,   -
//                                     want_count
//   out_*        out   status[1:0]    ready_source, ready_events,         last
//                                     ready_data
//
// With the output free, a request is accepted, the slots are scanned in turn
// and the final result is presented. The slot scan is bound by the single
// read port of the slot memory. Add, modify and delete stop at the slot they
// act on; harvest stops after want_count reports or at the last slot.
// Harvest holds while an earlier report waits on the output; the final result
// waits for a free output register. Reset clears the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module event_interest_table
  import eit_pkg::*;
#(
  parameter int ENTRIES     = EIT_ENTRIES,
  parameter int ONESHOT_BIT = EIT_ONESHOT_BIT
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // source_id[15:0], event_mask[47:16], user_data[111:48], want_count[116:112]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // mode[2:0]
  input  wire logic [MODE_W-1:0]      in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // ready_source[15:0], ready_events[47:16], ready_data[111:48]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0]         out_tuser,
  output logic                        out_tlast
);

  eit_cmd_t          cmd;
  eit_sts_t          sts;
  status_t           out_status;
  logic [SRC_W-1:0]  out_src;
  logic [MASK_W-1:0] out_events;
  logic [DATA_W-1:0] out_data;

  eit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eit_dp #(
    .ENTRIES     (ENTRIES),
    .ONESHOT_BIT (ONESHOT_BIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (in_tuser),
    .in_src     (in_tdata[15:0]),
    .in_mask    (in_tdata[47:16]),
    .in_data    (in_tdata[111:48]),
    .in_want    (in_tdata[116:112]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_src    (out_src),
    .out_events (out_events),
    .out_data   (out_data),
    .out_last   (out_tlast)
  );

  assign out_tdata = {out_data, out_events, out_src};
  assign out_tuser = out_status;

endmodule

`default_nettype wire

[rtl/eit_ctrl.sv]
// ----------------------------------------------------------------------------
// eit_ctrl
// Sequencer: takes a request, walks the slots one per cycle unless harvest
// stalls on the output, issues datapath commands and emits the final result.
// ----------------------------------------------------------------------------
`default_nettype none

module eit_ctrl
  import eit_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire eit_sts_t sts,
  output eit_cmd_t      cmd
);

  state_t  state_r, state_nxt;
  status_t fin_r, fin_nxt;

  logic hit, report, stall;

  assign hit    = sts.vld & sts.match;
  assign report = sts.vld & sts.ready_nz;
  assign stall  = report & sts.pend_vld & ~sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        unique case (sts.mode) inside
          OP_ADD: begin
            if (sts.full) begin
              state_nxt = S_FINISH;
              fin_nxt   = ST_FAIL;
            end else if (!sts.vld) begin
              state_nxt = S_FINISH;
              fin_nxt   = ST_OK;
            end else if (sts.at_end) begin
              state_nxt = S_FINISH;
              fin_nxt   = ST_FAIL;
            end
          end
          OP_MODIFY, OP_DELETE: begin
            if (hit) begin
              state_nxt = S_FINISH;
              fin_nxt   = ST_OK;
            end else if (sts.at_end) begin
              state_nxt = S_FINISH;
              fin_nxt   = ST_FAIL;
            end
          end
          OP_NOTIFY: begin
            if (sts.at_end) begin
              state_nxt = S_FINISH;
              fin_nxt   = ST_OK;
            end
          end
          OP_HARVEST: begin
            if (sts.want_zero) begin
              state_nxt = S_FINISH;
              fin_nxt   = ST_FAIL;
            end else if (report) begin
              if (!stall && (sts.want_hit || sts.at_end)) begin
                state_nxt = S_FINISH;
                fin_nxt   = ST_EMPTY;
              end
            end else if (sts.at_end) begin
              state_nxt = S_FINISH;
              fin_nxt   = ST_EMPTY;
            end
          end
          default: begin
            state_nxt = S_FINISH;
            fin_nxt   = ST_FAIL;
          end
        endcase
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd             = '0;
    cmd.emit_status = fin_r;
    in_tready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_SCAN: begin
        unique case (sts.mode) inside
          OP_ADD: begin
            if (!sts.full) begin
              if (!sts.vld) cmd.wr_add = 1'b1;
              else if (!sts.at_end) cmd.step = 1'b1;
            end
          end
          OP_MODIFY: begin
            if (hit) cmd.wr_mod = 1'b1;
            else if (!sts.at_end) cmd.step = 1'b1;
          end
          OP_DELETE: begin
            if (hit) cmd.del = 1'b1;
            else if (!sts.at_end) cmd.step = 1'b1;
          end
          OP_NOTIFY: begin
            cmd.wr_notify = hit & sts.overlap;
            cmd.step      = ~sts.at_end;
          end
          OP_HARVEST: begin
            if (!sts.want_zero) begin
              if (report) begin
                if (!stall) begin
                  cmd.take = 1'b1;
                  cmd.step = ~sts.want_hit & ~sts.at_end;
                end
              end else begin
                cmd.step = ~sts.at_end;
              end
            end
          end
          default: cmd.step = 1'b0;
        endcase
      end
      S_FINISH: begin
        cmd.emit = sts.out_free;
      end
      default: in_tready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/eit_dp.sv]
// ----------------------------------------------------------------------------
// eit_dp
// Slot storage, request operands, scan index, pending report and output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module eit_dp
  import eit_pkg::*;
#(
  parameter int ENTRIES     = EIT_ENTRIES,
  parameter int ONESHOT_BIT = EIT_ONESHOT_BIT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [SRC_W-1:0]  in_src,
  input  wire logic [MASK_W-1:0] in_mask,
  input  wire logic [DATA_W-1:0] in_data,
  input  wire logic [WANT_W-1:0] in_want,
  input  wire eit_cmd_t          cmd,
  output eit_sts_t               sts,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output status_t                out_status,
  output logic [SRC_W-1:0]       out_src,
  output logic [MASK_W-1:0]      out_events,
  output logic [DATA_W-1:0]      out_data,
  output logic                   out_last
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);
  localparam logic [WANT_W-1:0] WANT_MAX = WANT_W'(MOST_RESULTS);

  // operands
  logic [MODE_W-1:0] mode_r;
  logic [SRC_W-1:0]  src_r;
  logic [MASK_W-1:0] mask_r;
  logic [DATA_W-1:0] data_r;
  logic [WANT_W-1:0] want_r;
  logic [IDX_W-1:0]  idx_r;
  logic [WANT_W-1:0] found_r;

  // slot state
  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]   used_r;
  logic [SRC_W-1:0]   src_mem [ENTRIES];
  logic [MASK_W-1:0]  int_mem [ENTRIES];
  logic [MASK_W-1:0]  rdy_mem [ENTRIES];
  logic [DATA_W-1:0]  dat_mem [ENTRIES];

  logic [SRC_W-1:0]  rd_src_r;
  logic [MASK_W-1:0] rd_int_r;
  logic [MASK_W-1:0] rd_rdy_r;
  logic [DATA_W-1:0] rd_dat_r;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              int_we, rdy_we;
  logic [MASK_W-1:0] int_wd, rdy_wd;

  // pending report
  logic              pend_vld_r;
  logic [SRC_W-1:0]  pend_src_r;
  logic [MASK_W-1:0] pend_ev_r;
  logic [DATA_W-1:0] pend_dat_r;

  logic out_vld_r;
  logic out_free;
  logic push_take, push_emit;

  assign out_free = ~out_vld_r | out_tready;

  assign rd_en   = cmd.capture | cmd.step;
  assign rd_addr = cmd.capture ? '0 : idx_r + 1'b1;

  always_comb begin
    int_we = 1'b0;
    int_wd = mask_r;
    rdy_we = 1'b0;
    rdy_wd = '0;
    if (cmd.wr_add || cmd.wr_mod) begin
      int_we = 1'b1;
    end
    if (cmd.take && rd_int_r[ONESHOT_BIT]) begin
      int_we = 1'b1;
      int_wd = '0;
    end
    if (cmd.wr_add || cmd.take) begin
      rdy_we = 1'b1;
    end
    if (cmd.wr_notify) begin
      rdy_we = 1'b1;
      rdy_wd = rd_rdy_r | mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_src_r <= src_mem[rd_addr];
      rd_int_r <= int_mem[rd_addr];
      rd_rdy_r <= rdy_mem[rd_addr];
      rd_dat_r <= dat_mem[rd_addr];
    end
    if (cmd.wr_add) begin
      src_mem[idx_r] <= src_r;
    end
    if (cmd.wr_add || cmd.wr_mod) begin
      dat_mem[idx_r] <= data_r;
    end
    if (int_we) begin
      int_mem[idx_r] <= int_wd;
    end
    if (rdy_we) begin
      rdy_mem[idx_r] <= rdy_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      src_r   <= in_src;
      mask_r  <= in_mask;
      data_r  <= in_data;
      want_r  <= (in_want > WANT_MAX) ? WANT_MAX : in_want;
      idx_r   <= '0;
      found_r <= '0;
    end else begin
      if (cmd.step) idx_r <= idx_r + 1'b1;
      if (cmd.take) found_r <= found_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
    end else if (cmd.wr_add) begin
      valid_r[idx_r] <= 1'b1;
      used_r         <= used_r + 1'b1;
    end else if (cmd.del) begin
      valid_r[idx_r] <= 1'b0;
      if (used_r != '0) used_r <= used_r - 1'b1;
    end
  end

  assign push_take = cmd.take & pend_vld_r;
  assign push_emit = cmd.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd.take) pend_vld_r <= 1'b1;
      else if (cmd.emit) pend_vld_r <= 1'b0;
      if (push_take || push_emit) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_src_r <= rd_src_r;
      pend_ev_r  <= rd_rdy_r;
      pend_dat_r <= rd_dat_r;
    end
    if (push_take || (push_emit && pend_vld_r)) begin
      out_status <= ST_OK;
      out_src    <= pend_src_r;
      out_events <= pend_ev_r;
      out_data   <= pend_dat_r;
      out_last   <= push_emit;
    end else if (push_emit) begin
      out_status <= cmd.emit_status;
      out_src    <= '0;
      out_events <= '0;
      out_data   <= '0;
      out_last   <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;

  always_comb begin
    sts.mode      = mode_r;
    sts.full      = (used_r == FULL_CNT);
    sts.at_end    = (idx_r == LAST_IDX);
    sts.vld       = valid_r[idx_r];
    sts.match     = (rd_src_r == src_r);
    sts.overlap   = |(rd_int_r & mask_r);
    sts.ready_nz  = |rd_rdy_r;
    sts.want_zero = (want_r == '0);
    sts.want_hit  = ((found_r + 1'b1) == want_r);
    sts.pend_vld  = pend_vld_r;
    sts.out_free  = out_free;
  end

endmodule

`default_nettype wire

[rtl/eit_checker.sv]
// ----------------------------------------------------------------------------
// eit_checker
// Port-level checks for the event interest table.
// ----------------------------------------------------------------------------
`default_nettype none

module eit_checker
  import eit_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [STATUS_W-1:0]    out_tuser,
  input wire logic                   out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ST_OK || out_tuser == ST_FAIL || out_tuser == ST_EMPTY)
    else $error("illegal status code");

  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0 && out_tlast)
    else $error("fail or empty result not final or carries data");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind event_interest_table eit_checker u_eit_checker (.*);

`default_nettype wire
